@@ hw/rtl/a64dp_pkg.sv @@
// Shared constants, codes and types of the AArch64 data-processing execute stage.
// Used by arm64_data_proc_register_exec; depends on nothing else.
package a64dp_pkg;

   // Widths of the datapath and the register file
   localparam int XLEN   = 64;
   localparam int RIDX_W = 5;
   localparam int NREGS  = 31;
   localparam int NFLAGS = 4;

   // Stream word widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 80;

   // Register number that reads as zero and discards writes
   localparam logic [RIDX_W-1:0] ZERO_REG = 5'd31;

   // Low-word mask for 32-bit operation
   localparam logic [XLEN-1:0] MASK32 = 64'h0000_0000_FFFF_FFFF;

   // Request kinds carried in tuser
   typedef enum logic {
      REQ_EXEC = 1'b0,
      REQ_LOAD = 1'b1
   } req_kind_type;

   // Logical opcodes (opc field, shifted-register logical form)
   localparam logic [1:0] LOG_AND  = 2'd0;
   localparam logic [1:0] LOG_ORR  = 2'd1;
   localparam logic [1:0] LOG_EOR  = 2'd2;
   localparam logic [1:0] LOG_ANDS = 2'd3;

   // Shift kinds of the second operand
   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   // Multiply-accumulate encoding
   localparam logic [3:0] OPR_MADD = 4'd8;
   localparam logic [1:0] OPC_MADD = 2'd0;

   // Instruction word fields, most significant first
   typedef struct packed {
      logic        sf;
      logic [1:0]  opc;
      logic        m;
      logic [2:0]  grp;
      logic [3:0]  opr;
      logic [4:0]  rm;
      logic [5:0]  amt;
      logic [4:0]  rn;
      logic [4:0]  rd;
   } instr_type;

   // Sign bit of a value at the selected width
   function automatic logic msb_of(input logic [XLEN-1:0] v, input logic sf);
      return sf ? v[XLEN-1] : v[31];
   endfunction

endpackage

@@ hw/rtl/arm64_data_proc_register_exec.sv @@
// AArch64 data-processing-register execute stage: register file, flags and ALU.
// Depends on a64dp_pkg for widths, opcodes and the instruction field layout.
//
// Usage
//   The req channel takes one word per request. tuser selects the kind: execute
//   the instruction word in tdata, or load a value into a register. The rsp
//   channel returns one word per request: whether a register was written, the
//   register number (31 means discarded), the value and the flags after the
//   request.
//   The first stage captures an accepted request and reads the register file
//   (two copies, two and one read ports); the ALU, shifter and 32x32 partial
//   product multiplier then work on it and their result loads the rsp register.
//   A result written back is forwarded through a one-entry bypass to the
//   request right behind it.
//   Throughput is one request per cycle while rsp_tready stays high.
//   When the receiver stalls, the finished result waits in the rsp register and
//   one more request is taken into the first stage; then req_tready drops.
//   Reset clears the flags, the pipeline valids and the per-register valid bits,
//   so every register reads as zero at once; no clearing pass is needed.
module arm64_data_proc_register_exec (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // instr_word[31:0], load_index[36:32], load_value[100:37], zero pad
   input  logic [a64dp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_type[0]
   input  logic [0:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // did_write[0], dest_index[5:1], dest_value[69:6], nzcv[73:70], zero pad
   output logic [a64dp_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int XL = a64dp_pkg::XLEN;
   localparam int RW = a64dp_pkg::RIDX_W;

   // Input word fields
   a64dp_pkg::instr_type      req_instr;
   logic [RW-1:0]             req_ldidx;
   logic [XL-1:0]             req_ldval;
   logic                      accept;

   // First stage registers
   logic                      s1_vld_ff;
   a64dp_pkg::req_kind_type   s1_kind_ff;
   a64dp_pkg::instr_type      s1_instr_ff;
   logic [RW-1:0]             s1_ldidx_ff;
   logic [XL-1:0]             s1_ldval_ff;
   logic [XL-1:0]             op_n_ff, op_m_ff, op_a_ff;
   logic                      live_n_ff, live_m_ff, live_a_ff;

   // Register file: two copies, valid bits, bypass of the last write
   logic [XL-1:0]             mem_p_ff [a64dp_pkg::NREGS];
   logic [XL-1:0]             mem_q_ff [a64dp_pkg::NREGS];
   logic [(1<<RW)-1:0]        valid_ff;
   logic                      fwd_vld_ff;
   logic [RW-1:0]             fwd_idx_ff;
   logic [XL-1:0]             fwd_val_ff;
   logic [a64dp_pkg::NFLAGS-1:0] flags_ff;

   // Result register
   logic                      rsp_vld_ff;
   logic                      rsp_wr_ff;
   logic [RW-1:0]             rsp_idx_ff;
   logic [XL-1:0]             rsp_val_ff;
   logic [a64dp_pkg::NFLAGS-1:0] rsp_nzcv_ff;

   // Datapath signals
   logic                      s1_adv;
   logic [XL-1:0]             mask;
   logic [XL-1:0]             a_val, m_val, acc_val;
   logic [XL-1:0]             sext, sh_lsl, sh_lsr, sh_asr, sh_ror, shifted, b_val;
   logic [2*XL-1:0]           rot64;
   logic [63:0]               rot32;
   logic                      is_logical;
   logic [XL-1:0]             arith_res, logic_res;
   logic                      sa, sb, sr;
   logic [3:0]                arith_flags, logic_flags;
   logic [63:0]               prod_ll;
   logic [31:0]               prod_x;
   logic [XL-1:0]             prod, madd_res;
   logic                      wr_in;
   logic [RW-1:0]             idx_in;
   logic [XL-1:0]             val_in;
   logic                      setf_in;
   logic [3:0]                flags_in;
   logic [3:0]                nzcv_in;
   logic                      mem_we;

   // Unpack the request word
   assign req_instr = a64dp_pkg::instr_type'(req_tdata[31:0]);
   assign req_ldidx = req_tdata[36:32];
   assign req_ldval = req_tdata[100:37];

   // Handshake: first stage moves on when the result register is free or drains
   assign s1_adv     = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   // Capture the request and read the operands
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= a64dp_pkg::req_kind_type'(req_tuser[0]);
         s1_instr_ff <= req_instr;
         s1_ldidx_ff <= req_ldidx;
         s1_ldval_ff <= req_ldval;
         op_n_ff     <= mem_p_ff[req_instr.rn];
         op_m_ff     <= mem_p_ff[req_instr.rm];
         op_a_ff     <= mem_q_ff[req_instr.amt[RW-1:0]];
         live_n_ff   <= valid_ff[req_instr.rn];
         live_m_ff   <= valid_ff[req_instr.rm];
         live_a_ff   <= valid_ff[req_instr.amt[RW-1:0]];
      end
   end

   // Resolve operands: bypass of the previous write, else memory, else zero
   always_comb begin
      mask = s1_instr_ff.sf ? '1 : a64dp_pkg::MASK32;
      if (fwd_vld_ff && fwd_idx_ff == s1_instr_ff.rn) begin
         a_val = fwd_val_ff & mask;
      end else begin
         a_val = live_n_ff ? (op_n_ff & mask) : '0;
      end
      if (fwd_vld_ff && fwd_idx_ff == s1_instr_ff.rm) begin
         m_val = fwd_val_ff & mask;
      end else begin
         m_val = live_m_ff ? (op_m_ff & mask) : '0;
      end
      if (fwd_vld_ff && fwd_idx_ff == s1_instr_ff.amt[RW-1:0]) begin
         acc_val = fwd_val_ff & mask;
      end else begin
         acc_val = live_a_ff ? (op_a_ff & mask) : '0;
      end
   end

   // Shift and optionally invert the second operand
   always_comb begin
      is_logical = !s1_instr_ff.opr[3];
      sext   = s1_instr_ff.sf ? m_val : {{32{m_val[31]}}, m_val[31:0]};
      sh_lsl = (m_val << s1_instr_ff.amt) & mask;
      sh_lsr = m_val >> s1_instr_ff.amt;
      sh_asr = XL'($signed(sext) >>> s1_instr_ff.amt) & mask;
      rot64  = {m_val, m_val} >> s1_instr_ff.amt;
      rot32  = {m_val[31:0], m_val[31:0]} >> s1_instr_ff.amt[4:0];
      sh_ror = s1_instr_ff.sf ? rot64[XL-1:0] : {32'b0, rot32[31:0]};
      case (s1_instr_ff.opr[2:1])
         a64dp_pkg::SH_LSL: shifted = sh_lsl;
         a64dp_pkg::SH_LSR: shifted = sh_lsr;
         a64dp_pkg::SH_ASR: shifted = sh_asr;
         a64dp_pkg::SH_ROR: shifted = is_logical ? sh_ror : m_val;
         default:           shifted = m_val;
      endcase
      b_val = s1_instr_ff.opr[0] ? (~shifted & mask) : shifted;
   end

   // Add or subtract with flags
   always_comb begin
      arith_res = (s1_instr_ff.opc[1] ? a_val - b_val : a_val + b_val) & mask;
      sa = a64dp_pkg::msb_of(a_val, s1_instr_ff.sf);
      sb = a64dp_pkg::msb_of(b_val, s1_instr_ff.sf);
      sr = a64dp_pkg::msb_of(arith_res, s1_instr_ff.sf);
      arith_flags[3] = sr;
      arith_flags[2] = (arith_res == '0);
      if (s1_instr_ff.opc[1]) begin
         arith_flags[1] = (a_val >= b_val);
         arith_flags[0] = (sa != sb) && (sr == sb);
      end else begin
         arith_flags[1] = (arith_res < a_val);
         arith_flags[0] = (sa == sb) && (sr != sa);
      end
   end

   // Logical operations; ANDS clears C and V
   always_comb begin
      case (s1_instr_ff.opc)
         a64dp_pkg::LOG_AND:  logic_res = a_val & b_val;
         a64dp_pkg::LOG_ORR:  logic_res = a_val | b_val;
         a64dp_pkg::LOG_EOR:  logic_res = a_val ^ b_val;
         a64dp_pkg::LOG_ANDS: logic_res = a_val & b_val;
         default:             logic_res = a_val & b_val;
      endcase
      logic_flags = {a64dp_pkg::msb_of(logic_res, s1_instr_ff.sf), logic_res == '0, 2'b00};
   end

   // Low product bits from three 32x32 partial products, then add to or subtract from the accumulator
   always_comb begin
      prod_ll  = 64'(m_val[31:0]) * 64'(a_val[31:0]);
      prod_x   = 32'(a_val[31:0] * m_val[63:32]) + 32'(a_val[63:32] * m_val[31:0]);
      prod     = (prod_ll + {prod_x, 32'b0}) & mask;
      madd_res = (s1_instr_ff.amt[5] ? acc_val - prod : acc_val + prod) & mask;
   end

   // Select the result of the request
   always_comb begin
      wr_in    = 1'b0;
      idx_in   = '0;
      val_in   = '0;
      setf_in  = 1'b0;
      flags_in = arith_flags;
      if (s1_kind_ff == a64dp_pkg::REQ_LOAD) begin
         wr_in  = 1'b1;
         idx_in = s1_ldidx_ff;
         val_in = s1_ldval_ff;
      end else if (!s1_instr_ff.m) begin
         wr_in  = 1'b1;
         idx_in = s1_instr_ff.rd;
         if (is_logical) begin
            val_in   = logic_res;
            setf_in  = (s1_instr_ff.opc == a64dp_pkg::LOG_ANDS);
            flags_in = logic_flags;
         end else begin
            val_in  = arith_res;
            setf_in = s1_instr_ff.opc[0];
         end
      end else if (s1_instr_ff.opr == a64dp_pkg::OPR_MADD &&
                   s1_instr_ff.opc == a64dp_pkg::OPC_MADD) begin
         wr_in  = 1'b1;
         idx_in = s1_instr_ff.rd;
         val_in = madd_res;
      end
      nzcv_in = setf_in ? flags_in : flags_ff;
      mem_we  = s1_adv && wr_in && (idx_in != a64dp_pkg::ZERO_REG);
   end

   // Write back into both register file copies
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_p_ff[idx_in] <= val_in;
         mem_q_ff[idx_in] <= val_in;
      end
   end

   // Valid bits, bypass entry and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         fwd_vld_ff <= 1'b0;
         flags_ff   <= '0;
      end else if (s1_adv) begin
         if (mem_we) begin
            valid_ff[idx_in] <= 1'b1;
         end
         fwd_vld_ff <= mem_we;
         flags_ff   <= nzcv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fwd_idx_ff <= idx_in;
         fwd_val_ff <= val_in;
      end
   end

   // Result register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_wr_ff   <= wr_in;
         rsp_idx_ff  <= idx_in;
         rsp_val_ff  <= val_in;
         rsp_nzcv_ff <= nzcv_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'b0, rsp_nzcv_ff, rsp_val_ff, rsp_idx_ff, rsp_wr_ff};

   // Register 31 never becomes valid
   a_zero_reg_never_valid: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[a64dp_pkg::ZERO_REG])
      else $error("register 31 marked valid");

   // Bypass never holds the discarded register
   a_fwd_idx: assert property (@(posedge clock) disable iff (reset)
      fwd_vld_ff |-> fwd_idx_ff != a64dp_pkg::ZERO_REG)
      else $error("bypass holds register 31");

   // A result without a write carries zero index and value
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_wr_ff) |-> (rsp_idx_ff == '0 && rsp_val_ff == '0))
      else $error("unhandled encoding reports data");

   // Flags change only when a request retires
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(s1_adv)) |-> $stable(flags_ff))
      else $error("flags changed without a retiring request");

   // Input stalls only while the first stage is occupied
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_vld_ff && rsp_vld_ff && !rsp_tready))
      else $error("input stalled without a blocked first stage");

endmodule
